FILE: src/ffha_pkg.sv
// Types and constants shared by the allocator top level, its checker and its testbench.
package ffha_pkg;

	localparam logic [1:0] MODE_ALLOC     = 2'd0;
	localparam logic [1:0] MODE_FREE      = 2'd1;
	localparam logic [1:0] MODE_FREE_ALL  = 2'd2;
	localparam logic [1:0] MODE_QUERY     = 2'd3;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_ZERO_SIZE   = 2'd1;
	localparam logic [1:0] ST_NO_MEM      = 2'd2;
	localparam logic [1:0] ST_NOT_LIVE    = 2'd3;

	localparam logic [0:0] REG_BASE       = 1'b0;
	localparam logic [0:0] REG_SIZE       = 1'b1;

	localparam logic [32:0] ROUND_ADD     = 33'd15;
	localparam logic [32:0] ROUND_MASK    = ~33'd15;

	localparam logic [31:0] BASE_RESET    = 32'h0E00_0000;
	localparam logic [31:0] SIZE_RESET    = 32'h00E0_0000;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  owner;
		logic [31:0] request_size;
		logic [31:0] block_addr_in;
	} ffha_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted_addr;
		logic [6:0]  owner_block_count;
		logic        addr_is_live;
	} ffha_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_ALLOC_SCAN,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_SHIFT_UP_RD,
		S_SHIFT_UP_WR,
		S_SPLIT_WR,
		S_FIND_RD,
		S_FIND_CHK,
		S_REL_RD_NEXT,
		S_REL_NEXT_CHK,
		S_REL_RD_PREV,
		S_REL_PREV_CHK,
		S_REM_RD,
		S_REM_WR,
		S_FA_RD,
		S_FA_CHK,
		S_CNT_RD,
		S_CNT_CHK,
		S_DONE
	} ffha_state_t;

endpackage

FILE: src/ffha_table.sv
// Block table memory: one write port and one registered read port.
module ffha_table #(
	parameter int MAX_BLOCKS = 64,
	parameter int OWNER_BITS = 8
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(MAX_BLOCKS)-1:0] waddr,
	input  logic [31:0]                   wstart,
	input  logic [31:0]                   wlength,
	input  logic                          wused,
	input  logic [OWNER_BITS-1:0]         wowner,
	input  logic [$clog2(MAX_BLOCKS)-1:0] raddr,
	output logic [31:0]                   rstart,
	output logic [31:0]                   rlength,
	output logic                          rused,
	output logic [OWNER_BITS-1:0]         rowner
);
	localparam int W = 32 + 32 + 1 + OWNER_BITS;

	logic [W-1:0] mem [MAX_BLOCKS];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wstart, wlength, wused, wowner};
		end
		rdata_q <= mem[raddr];
	end

	assign {rstart, rlength, rused, rowner} = rdata_q;
endmodule

FILE: src/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with owner tags and coalescing.
// Steps: alloc scans and shifts, free finds and shifts, free-all resumes its scan after
// each release, and every item ends with an owner count walk over the used entries.
// Throughput: one item at a time; busy stays high through the result strobe.
// Reset and every register write rebuild the table: a clearing pass over all
// MAX_BLOCKS entries runs while busy is high. Results cannot be stalled.
module first_fit_heap_allocator #(
	parameter int MAX_BLOCKS = 64,
	parameter int OWNER_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ffha_pkg::ffha_req_t req,
	output logic               done,
	output ffha_pkg::ffha_rsp_t rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ffha_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

	ffha_state_t state_q, state_d;
	ffha_state_t rel_exit;

	logic [31:0] base_q, size_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] i_q, j_q, hit_q;
	logic [1:0]  mode_q, status_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [31:0] size_in_q, addr_q, granted_q;
	logic [32:0] need_q;
	logic [31:0] cur_start_q, cur_len_q;
	logic [6:0]  count_q;
	logic        live_q, found_q, phase_q;

	logic [CW-1:0] i_next, used_next, rel_i;
	logic st_set, gr_set, cnt_inc, live_set, found_set, cur_set, curlen_set;
	logic j_set, hit_set, phase_d;
	logic [1:0] st_val;
	logic [31:0] cur_len_d, gr_d;
	logic [CW-1:0] j_d, hit_d;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wstart, wlength;
	logic          wused;
	logic [OWNER_BITS-1:0] wowner;
	logic [31:0]   rstart, rlength;
	logic          rused;
	logic [OWNER_BITS-1:0] rowner;

	ffha_table #(.MAX_BLOCKS(MAX_BLOCKS), .OWNER_BITS(OWNER_BITS)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wstart(wstart), .wlength(wlength),
		.wused(wused), .wowner(wowner), .raddr(raddr), .rstart(rstart),
		.rlength(rlength), .rused(rused), .rowner(rowner)
	);

	logic [31:0] cur_end;
	logic [31:0] rd_end;
	assign cur_end = cur_start_q + cur_len_q;
	assign rd_end  = rstart + rlength;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;

	assign rel_exit = (mode_q == MODE_FREE_ALL) ? S_FA_RD : S_CNT_RD;
	assign rel_i    = (mode_q == MODE_FREE_ALL) ? i_q : '0;

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			base_q  <= BASE_RESET;
			size_q  <= SIZE_RESET;
			used_q  <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && cfg_valid && !start) begin
				if (cfg_index == REG_BASE) base_q <= cfg_data;
				else size_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) i_q <= '0;
					else if (start) i_q <= '0;
				end
				S_INIT: begin
					i_q    <= i_q + 1'b1;
					used_q <= CW'(1);
				end
				default: begin
					i_q <= i_next;
					used_q <= used_next;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q    <= req.mode;
			owner_q   <= OWNER_BITS'(req.owner);
			size_in_q <= req.request_size;
			addr_q    <= req.block_addr_in;
			need_q    <= ({1'b0, req.request_size} + ROUND_ADD) & ROUND_MASK;
			status_q  <= ST_OK;
			granted_q <= '0;
			count_q   <= '0;
			live_q    <= 1'b0;
			found_q   <= 1'b0;
			phase_q   <= 1'b0;
		end else begin
			if (st_set) status_q <= st_val;
			if (gr_set) granted_q <= gr_d;
			if (cnt_inc) count_q <= count_q + 1'b1;
			if (live_set) live_q <= 1'b1;
			if (found_set) found_q <= 1'b1;
			if (cur_set) begin
				cur_start_q <= rstart;
				cur_len_q   <= rlength;
			end
			if (curlen_set) cur_len_q <= cur_len_d;
			if (j_set) j_q <= j_d;
			if (hit_set) hit_q <= hit_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d = state_q;
		i_next = i_q; used_next = used_q;
		we = 1'b0; waddr = '0; raddr = i_q[AW-1:0];
		wstart = '0; wlength = '0; wused = 1'b0; wowner = '0;
		st_set = 1'b0; st_val = ST_OK; gr_set = 1'b0; gr_d = rstart; cnt_inc = 1'b0;
		live_set = 1'b0; found_set = 1'b0; cur_set = 1'b0; curlen_set = 1'b0;
		cur_len_d = cur_len_q; j_set = 1'b0; j_d = j_q; hit_set = 1'b0;
		hit_d = hit_q; phase_d = phase_q;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (req.mode)
						MODE_ALLOC:    state_d = S_ALLOC_SCAN;
						MODE_FREE:     state_d = S_FIND_RD;
						MODE_FREE_ALL: state_d = S_FA_RD;
						default:       state_d = S_CNT_RD;
					endcase
				end else if (cfg_valid) state_d = S_INIT;
			end
			S_INIT: begin
				we = 1'b1; waddr = i_q[AW-1:0];
				if (i_q == '0) begin
					wstart = base_q; wlength = size_q;
				end
				if (i_q == MAXC - 1'b1) state_d = S_IDLE;
			end
			S_ALLOC_SCAN: begin
				if (size_in_q == '0) begin
					st_set = 1'b1; st_val = ST_ZERO_SIZE; state_d = S_CNT_RD;
					i_next = '0;
				end else if (size_in_q >= size_q) begin
					st_set = 1'b1; st_val = ST_NO_MEM; state_d = S_CNT_RD;
					i_next = '0;
				end else state_d = S_ALLOC_RD;
			end
			S_ALLOC_RD: begin
				if (i_q >= used_q) begin
					st_set = 1'b1; st_val = ST_NO_MEM; state_d = S_CNT_RD;
					i_next = '0;
				end else state_d = S_ALLOC_CHK;
			end
			S_ALLOC_CHK: begin
				if (rused || {1'b0, rlength} < need_q) begin
					i_next = i_q + 1'b1; state_d = S_ALLOC_RD;
				end else if ({1'b0, rlength} > need_q) begin
					if (used_q >= MAXC) begin
						st_set = 1'b1; st_val = ST_NO_MEM; state_d = S_CNT_RD;
						i_next = '0;
					end else begin
						cur_set = 1'b1; hit_set = 1'b1; hit_d = i_q;
						j_set = 1'b1; j_d = used_q; state_d = S_SHIFT_UP_RD;
					end
				end else begin
					we = 1'b1; waddr = i_q[AW-1:0]; wstart = rstart;
					wlength = need_q[31:0]; wused = 1'b1; wowner = owner_q;
					gr_set = 1'b1; state_d = S_CNT_RD; i_next = '0;
				end
			end
			S_SHIFT_UP_RD: begin
				if (j_q > hit_q + 1'b1) begin
					raddr = AW'(j_q - 1'b1); state_d = S_SHIFT_UP_WR;
				end else state_d = S_SPLIT_WR;
			end
			S_SHIFT_UP_WR: begin
				we = 1'b1; waddr = j_q[AW-1:0]; wstart = rstart; wlength = rlength;
				wused = rused; wowner = rowner;
				j_set = 1'b1; j_d = j_q - 1'b1; state_d = S_SHIFT_UP_RD;
			end
			S_SPLIT_WR: begin
				we = 1'b1;
				if (!phase_q) begin
					waddr = AW'(hit_q + 1'b1);
					wstart = cur_start_q + need_q[31:0];
					wlength = cur_len_q - need_q[31:0];
					phase_d = 1'b1;
				end else begin
					waddr = hit_q[AW-1:0]; wstart = cur_start_q;
					wlength = need_q[31:0]; wused = 1'b1; wowner = owner_q;
					phase_d = 1'b0; used_next = used_q + 1'b1;
					gr_set = 1'b1; gr_d = cur_start_q;
					state_d = S_CNT_RD; i_next = '0;
				end
			end
			S_FIND_RD: begin
				if (i_q >= used_q) begin
					st_set = 1'b1; st_val = ST_NOT_LIVE; state_d = S_CNT_RD;
					i_next = '0;
				end else state_d = S_FIND_CHK;
			end
			S_FIND_CHK: begin
				if (rstart == addr_q) begin
					if (!rused || rowner != owner_q) begin
						st_set = 1'b1; st_val = ST_NOT_LIVE; state_d = S_CNT_RD;
						i_next = '0;
					end else begin
						hit_set = 1'b1; hit_d = i_q; phase_d = 1'b0;
						we = 1'b1; waddr = i_q[AW-1:0]; wstart = rstart;
						wlength = rlength;
						cur_set = 1'b1; state_d = S_REL_RD_NEXT;
					end
				end else begin
					i_next = i_q + 1'b1; state_d = S_FIND_RD;
				end
			end
			S_REL_RD_NEXT: begin
				if (hit_q + 1'b1 < used_q) begin
					raddr = AW'(hit_q + 1'b1); state_d = S_REL_NEXT_CHK;
				end else state_d = S_REL_RD_PREV;
			end
			S_REL_NEXT_CHK: begin
				if (!rused && rstart == cur_end) begin
					cur_len_d = cur_len_q + rlength; curlen_set = 1'b1;
					we = 1'b1; waddr = hit_q[AW-1:0]; wstart = cur_start_q;
					wlength = cur_len_q + rlength;
					j_set = 1'b1; j_d = hit_q + 1'b1; phase_d = 1'b0;
					state_d = S_REM_RD;
				end else state_d = S_REL_RD_PREV;
			end
			S_REL_RD_PREV: begin
				if (hit_q != '0) begin
					raddr = AW'(hit_q - 1'b1); state_d = S_REL_PREV_CHK;
				end else begin
					state_d = rel_exit; i_next = rel_i;
				end
			end
			S_REL_PREV_CHK: begin
				if (!rused && rd_end == cur_start_q) begin
					we = 1'b1; waddr = AW'(hit_q - 1'b1); wstart = rstart;
					wlength = rlength + cur_len_q;
					j_set = 1'b1; j_d = hit_q; phase_d = 1'b1;
					state_d = S_REM_RD;
				end else begin
					state_d = rel_exit; i_next = rel_i;
				end
			end
			S_REM_RD: begin
				if (j_q + 1'b1 < used_q) begin
					raddr = AW'(j_q + 1'b1); state_d = S_REM_WR;
				end else begin
					we = 1'b1; waddr = AW'(used_q - 1'b1);
					used_next = used_q - 1'b1;
					if (phase_q) begin
						state_d = rel_exit; i_next = rel_i;
					end else state_d = S_REL_RD_PREV;
				end
			end
			S_REM_WR: begin
				we = 1'b1; waddr = j_q[AW-1:0]; wstart = rstart; wlength = rlength;
				wused = rused; wowner = rowner;
				j_set = 1'b1; j_d = j_q + 1'b1; state_d = S_REM_RD;
			end
			S_FA_RD: begin
				if (i_q >= used_q) begin
					state_d = S_CNT_RD; i_next = '0;
				end else state_d = S_FA_CHK;
			end
			S_FA_CHK: begin
				if (rused && rowner == owner_q) begin
					hit_set = 1'b1; hit_d = i_q; phase_d = 1'b0;
					we = 1'b1; waddr = i_q[AW-1:0]; wstart = rstart;
					wlength = rlength;
					cur_set = 1'b1; state_d = S_REL_RD_NEXT;
				end else begin
					i_next = i_q + 1'b1; state_d = S_FA_RD;
				end
			end
			S_CNT_RD: begin
				if (i_q >= used_q) state_d = S_DONE;
				else state_d = S_CNT_CHK;
			end
			S_CNT_CHK: begin
				if (rused && rowner == owner_q) cnt_inc = 1'b1;
				if (rstart == addr_q && !found_q) begin
					found_set = 1'b1;
					if (rused) live_set = 1'b1;
				end
				i_next = i_q + 1'b1; state_d = S_CNT_RD;
			end
			S_DONE: begin
				done = 1'b1; state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rsp.status            = status_q;
	assign rsp.granted_addr      = granted_q;
	assign rsp.owner_block_count = count_q;
	assign rsp.addr_is_live      = live_q;
endmodule

FILE: src/ffha_checker.sv
// Port-level checks for the heap allocator, bound to the top level.
module ffha_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input ffha_pkg::ffha_rsp_t rsp,
	input logic               cfg_valid,
	input logic               cfg_ready
);
	import ffha_pkg::*;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.granted_addr == '0)
		else $error("address granted on failure");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy) else $error("config ready while busy");
	a_xfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) || (cfg_valid && cfg_ready) |=> busy)
		else $error("idle after a transfer");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

FILE: bench/first_fit_heap_allocator_tb.sv
// Self-checking testbench for the first-fit heap allocator: directed table, random traffic.
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam int TBL_DEPTH = 64;
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		ffha_req_t r;
		bit        typed;
		ffha_rsp_t e;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	ffha_req_t         req = '0;
	logic              done;
	ffha_rsp_t         rsp;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [0:0]        cfg_index = REG_BASE;
	logic [31:0]       cfg_data = '0;

	logic [31:0] heap_base;
	logic [31:0] heap_size;
	logic [31:0] blk_start [TBL_DEPTH];
	logic [31:0] blk_len [TBL_DEPTH];
	bit          blk_used [TBL_DEPTH];
	logic [7:0]  blk_owner [TBL_DEPTH];
	int          blk_count;

	ffha_rsp_t pending_rsp [$];
	dir_row_t  dir_rows [$];
	int        mismatches = 0;
	int        items_sent = 0;
	int        results_seen = 0;
	int        no_mem_seen = 0;
	int        stall_cycles = 0;
	int        gap_pct = 38;

	first_fit_heap_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void heap_clear();
		for (int i = 0; i < TBL_DEPTH; i++) begin
			blk_start[i] = '0;
			blk_len[i] = '0;
			blk_used[i] = 1'b0;
			blk_owner[i] = '0;
		end
		blk_start[0] = heap_base;
		blk_len[0] = heap_size;
		blk_count = 1;
	endfunction

	function automatic void heap_drop(int idx);
		for (int i = idx; i + 1 < blk_count; i++) begin
			blk_start[i] = blk_start[i + 1];
			blk_len[i] = blk_len[i + 1];
			blk_used[i] = blk_used[i + 1];
			blk_owner[i] = blk_owner[i + 1];
		end
		blk_count--;
		blk_start[blk_count] = '0;
		blk_len[blk_count] = '0;
		blk_used[blk_count] = 1'b0;
		blk_owner[blk_count] = '0;
	endfunction

	function automatic int heap_lookup(logic [31:0] addr);
		for (int i = 0; i < blk_count; i++)
			if (blk_start[i] == addr)
				return i;
		return -1;
	endfunction

	function automatic void heap_release(int idx);
		blk_used[idx] = 1'b0;
		blk_owner[idx] = '0;
		if (idx + 1 < blk_count && !blk_used[idx + 1] &&
				blk_start[idx + 1] == blk_start[idx] + blk_len[idx]) begin
			blk_len[idx] = blk_len[idx] + blk_len[idx + 1];
			heap_drop(idx + 1);
		end
		if (idx > 0 && !blk_used[idx - 1] &&
				blk_start[idx - 1] + blk_len[idx - 1] == blk_start[idx]) begin
			blk_len[idx - 1] = blk_len[idx - 1] + blk_len[idx];
			heap_drop(idx);
		end
	endfunction

	function automatic logic [1:0] heap_alloc(logic [7:0] own, logic [31:0] size,
			output logic [31:0] granted);
		logic [32:0] need;
		granted = '0;
		if (size == 0)
			return ST_ZERO_SIZE;
		if (size >= heap_size)
			return ST_NO_MEM;
		need = ({1'b0, size} + ROUND_ADD) & ROUND_MASK;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_used[i] || {1'b0, blk_len[i]} < need)
				continue;
			if ({1'b0, blk_len[i]} > need) begin
				if (blk_count >= TBL_DEPTH)
					return ST_NO_MEM;
				for (int j = blk_count; j > i + 1; j--) begin
					blk_start[j] = blk_start[j - 1];
					blk_len[j] = blk_len[j - 1];
					blk_used[j] = blk_used[j - 1];
					blk_owner[j] = blk_owner[j - 1];
				end
				blk_start[i + 1] = blk_start[i] + need[31:0];
				blk_len[i + 1] = blk_len[i] - need[31:0];
				blk_used[i + 1] = 1'b0;
				blk_owner[i + 1] = '0;
				blk_count++;
			end
			blk_len[i] = need[31:0];
			blk_used[i] = 1'b1;
			blk_owner[i] = own;
			granted = blk_start[i];
			return ST_OK;
		end
		return ST_NO_MEM;
	endfunction

	function automatic ffha_rsp_t heap_apply(ffha_req_t r);
		ffha_rsp_t o;
		logic [31:0] g;
		int k;
		int i;
		int cnt;
		o = '0;
		g = '0;
		case (r.mode)
			MODE_ALLOC: begin
				o.status = heap_alloc(r.owner, r.request_size, g);
			end
			MODE_FREE: begin
				k = heap_lookup(r.block_addr_in);
				if (k < 0 || !blk_used[k] || blk_owner[k] != r.owner)
					o.status = ST_NOT_LIVE;
				else
					heap_release(k);
			end
			MODE_FREE_ALL: begin
				i = 0;
				while (i < blk_count) begin
					if (blk_used[i] && blk_owner[i] == r.owner) begin
						heap_release(i);
						i = 0;
					end else begin
						i++;
					end
				end
			end
			default: ;
		endcase
		cnt = 0;
		for (i = 0; i < blk_count; i++)
			if (blk_used[i] && blk_owner[i] == r.owner)
				cnt++;
		k = heap_lookup(r.block_addr_in);
		o.granted_addr = (o.status == ST_OK) ? g : 32'd0;
		o.owner_block_count = cnt[6:0];
		o.addr_is_live = (k >= 0) && blk_used[k];
		return o;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (rsp.status == ST_NO_MEM)
				no_mem_seen++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", rsp);
			end else begin
				ffha_rsp_t e;
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status || rsp.granted_addr !== e.granted_addr ||
						rsp.owner_block_count !== e.owner_block_count ||
						rsp.addr_is_live !== e.addr_is_live) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: expected %p, got %p", $realtime, e, rsp);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("first_fit_heap_allocator verification failed");
				$finish;
			end
		end
	end

	task automatic send_item(ffha_req_t r, bit typed, ffha_rsp_t e);
		ffha_rsp_t p;
		int gap;
		gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (!(start && !busy));
		p = heap_apply(r);
		pending_rsp = {pending_rsp, (typed ? e : p)};
		items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		if (idx == REG_BASE)
			heap_base = val;
		else
			heap_size = val;
		heap_clear();
	endtask

	function automatic ffha_req_t random_item();
		ffha_req_t r;
		int pick;
		r.owner = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
		pick = $urandom_range(99);
		r.mode = (pick < 47) ? MODE_ALLOC : (pick < 82) ? MODE_FREE :
			(pick < 86) ? MODE_FREE_ALL : MODE_QUERY;
		pick = $urandom_range(99);
		if (pick < 75)
			r.request_size = $urandom_range(1, (heap_size / 24 > 16) ? heap_size / 24 : 16);
		else if (pick < 90)
			r.request_size = $urandom_range(0, heap_size);
		else
			r.request_size = $urandom;
		if ($urandom_range(9) < 8)
			r.block_addr_in = blk_start[$urandom_range(blk_count - 1)];
		else
			r.block_addr_in = $urandom;
		return r;
	endfunction

	task automatic random_phase(int n);
		ffha_req_t r;
		for (int i = 0; i < n; i++) begin
			r = random_item();
			if (i % 400 == 0) begin
				for (int j = 0; j < 70; j++) begin
					r.mode = MODE_ALLOC;
					r.owner = 8'($urandom_range(3));
					r.request_size = $urandom_range(1, 32);
					send_item(r, 1'b0, '0);
				end
			end
			if (i == n / 2)
				drain();
			send_item(r, 1'b0, '0);
		end
	endtask

	function automatic void add_row(logic [1:0] m, logic [7:0] o, logic [31:0] sz,
			logic [31:0] a, bit typed, ffha_rsp_t e);
		dir_row_t d;
		d.r = '{mode: m, owner: o, request_size: sz, block_addr_in: a};
		d.typed = typed;
		d.e = e;
		dir_rows = {dir_rows, d};
	endfunction

	initial begin
		heap_base = BASE_RESET;
		heap_size = SIZE_RESET;
		heap_clear();

		add_row(MODE_ALLOC, 8'd1, 32'd0, 32'd0, 1, '{ST_ZERO_SIZE, 32'd0, 7'd0, 1'b0});
		add_row(MODE_ALLOC, 8'd1, 32'hFFFF_FFFF, 32'd0, 1, '{ST_NO_MEM, 32'd0, 7'd0, 1'b0});
		add_row(MODE_ALLOC, 8'd1, SIZE_RESET, 32'd0, 1, '{ST_NO_MEM, 32'd0, 7'd0, 1'b0});
		add_row(MODE_ALLOC, 8'd1, 32'd1, BASE_RESET, 1, '{ST_OK, BASE_RESET, 7'd1, 1'b1});
		add_row(MODE_ALLOC, 8'd1, 32'd17, 32'h0E00_0010, 0, '0);
		add_row(MODE_ALLOC, 8'd2, 32'd32, 32'h0E00_0030, 0, '0);
		add_row(MODE_FREE, 8'd2, 32'd0, 32'h0E00_0010, 1, '{ST_NOT_LIVE, 32'd0, 7'd1, 1'b1});
		add_row(MODE_FREE, 8'd1, 32'd0, 32'd0, 0, '0);
		add_row(MODE_FREE, 8'd1, 32'd0, 32'h0E00_0010, 0, '0);
		add_row(MODE_FREE, 8'd1, 32'd0, 32'h0E00_0010, 0, '0);
		add_row(MODE_QUERY, 8'd2, 32'hFFFF_FFFF, 32'h0E00_0030, 0, '0);
		add_row(MODE_FREE_ALL, 8'd1, 32'd0, BASE_RESET, 0, '0);
		add_row(MODE_FREE_ALL, 8'd7, 32'd0, 32'd0, 0, '0);
		add_row(MODE_ALLOC, 8'd255, SIZE_RESET - 32'd1, 32'd0, 0, '0);
		add_row(MODE_FREE_ALL, 8'd2, 32'd0, 32'hFFFF_FFFF, 0, '0);
		add_row(MODE_ALLOC, 8'd255, SIZE_RESET - 32'd1, BASE_RESET, 0, '0);
		add_row(MODE_FREE, 8'd255, 32'd0, BASE_RESET, 0, '0);
		add_row(MODE_FREE_ALL, 8'd255, 32'd0, BASE_RESET, 0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);
		random_phase(150);

		write_reg(REG_BASE, 32'h0000_0000);
		write_reg(REG_SIZE, 32'h0000_1000);
		random_phase(330);

		gap_pct = 85;
		write_reg(REG_BASE, 32'hFFFF_FF00);
		write_reg(REG_SIZE, 32'h0000_0400);
		random_phase(300);

		write_reg(REG_BASE, 32'h1234_5670);
		write_reg(REG_SIZE, 32'hFFFF_FFF0);
		random_phase(230);

		gap_pct = 0;
		write_reg(REG_SIZE, 32'h0000_0010);
		random_phase(90);

		write_reg(REG_BASE, 32'hFFFF_FFFF);
		write_reg(REG_SIZE, 32'h0000_0800);
		random_phase(250);

		drain();
		repeat (200) @(posedge clk);
		$display("sent %0d items over six region settings, %0d results checked,",
			items_sent, results_seen);
		$display("%0d out-of-memory results, %0d mismatches", no_mem_seen, mismatches);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("first_fit_heap_allocator verification clean");
		else
			$display("first_fit_heap_allocator verification failed");
		$finish;
	end

endmodule

FILE: first_fit_heap_allocator.f
src/ffha_pkg.sv
src/ffha_table.sv
src/first_fit_heap_allocator.sv
src/ffha_checker.sv
bench/first_fit_heap_allocator_tb.sv
